// ----- rtl/core/ipd_pkg.sv -----
// Shared types, constants and helpers for the +IPD publish deframer.
// Depends on nothing; every other file of the block imports it.
package ipd_pkg;

    // Frame, topic and message limits (16-bit quantities).
    localparam logic [15:0] FRAME_LIMIT   = 16'd512;
    localparam logic [15:0] TOPIC_LIMIT   = 16'd64;
    localparam logic [15:0] MESSAGE_LIMIT = 16'd256;

    // Default depth of the queue between parser and output stage.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Header byte test: high nibble of a publish header.
    localparam logic [7:0] HDR_MASK    = 8'hF0;
    localparam logic [7:0] HDR_PUBLISH = 8'h30;

    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_HUNT       = 3'd0,
        PH_LEN_FIRST  = 3'd1,
        PH_LEN_DIGITS = 3'd2,
        PH_SKIP       = 3'd3,
        PH_PAYLOAD    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_TOPIC     = 2'd0,
        EV_MESSAGE   = 2'd1,
        EV_MALFORMED = 2'd2,
        EV_OVERFLOW  = 2'd3
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        t_event     event_res;
        logic       end_of_message;
    } t_result;

    // Characters of the "+IPD," prefix, by match position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h2B;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/ipd_front.sv -----
// Front part: byte parser for the +IPD stream and the publish decoder.
// Depends on ipd_pkg; pushes result beats into ipd_queue.
module ipd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_push,
    output ipd_pkg::t_result o_res
);
    import ipd_pkg::*;

    localparam logic [15:0] MSG_CAP = MESSAGE_LIMIT - 16'd1;
    // A first non-digit after the length is byte one of the skip count.
    localparam logic SKIP_FIRST_OVF = (17'd1 >= {1'b0, FRAME_LIMIT});

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pm, n_pm;
    logic [15:0] r_dl, n_dl;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_tl, n_tl;
    logic        r_pa, n_pa;
    logic [15:0] r_me, n_me;
    logic [15:0] r_cap, n_cap;
    logic        r_deliver_enable;

    logic        w_digit, w_colon, w_plus;
    logic [19:0] w_len_x10;
    logic [15:0] w_len_next;
    logic [16:0] w_pos_inc;
    logic        w_len_over, w_len_zero, w_skip_ovf, w_pay_done;
    logic [15:0] w_tl_new, w_cap_raw, w_cap, w_me_inc;
    logic        w_topic_bad, w_pub_start, w_pos_ge4, w_in_topic, w_msg_more;
    logic [2:0]  w_idx;
    logic        w_prefix_hit;

    assign w_digit    = (i_rx_byte >= CHR_ZERO) && (i_rx_byte <= CHR_NINE);
    assign w_colon    = (i_rx_byte == CHR_COLON);
    assign w_plus     = (i_rx_byte == CHR_PLUS);
    assign w_len_x10  = {1'b0, r_dl, 3'd0} + {3'd0, r_dl, 1'b0} + {16'd0, i_rx_byte[3:0]};
    assign w_len_next = (w_len_x10 > 20'h0FFFF) ? 16'hFFFF : w_len_x10[15:0];
    assign w_pos_inc  = {1'b0, r_pos} + 17'd1;
    assign w_len_over = (r_dl > FRAME_LIMIT);
    assign w_len_zero = (r_dl == 16'd0);
    assign w_skip_ovf = (w_pos_inc >= {1'b0, FRAME_LIMIT});
    assign w_pay_done = (w_pos_inc >= {1'b0, r_dl});

    assign w_tl_new    = {r_tl[15:8], i_rx_byte};
    assign w_topic_bad = !((({1'b0, w_tl_new} + 17'd4) < {1'b0, r_dl}) &&
                           (w_tl_new < TOPIC_LIMIT));
    assign w_cap_raw   = r_dl - 16'd4 - w_tl_new;
    assign w_cap       = (w_cap_raw > MSG_CAP) ? MSG_CAP : w_cap_raw;
    assign w_pub_start = (r_dl > 16'd4) && ((i_rx_byte & HDR_MASK) == HDR_PUBLISH) &&
                         r_deliver_enable;
    assign w_pos_ge4   = (r_pos >= 16'd4);
    assign w_in_topic  = ({1'b0, r_pos} < ({1'b0, r_tl} + 17'd4));
    assign w_msg_more  = (r_me < r_cap);
    assign w_me_inc    = r_me + 16'd1;

    assign w_idx        = (r_pm > 3'd4) ? 3'd0 : r_pm;
    assign w_prefix_hit = (i_rx_byte == prefix_char(w_idx));

    // Next-state logic.
    always_comb begin
        n_phase = r_phase;
        n_pm    = r_pm;
        n_dl    = r_dl;
        n_pos   = r_pos;
        n_tl    = r_tl;
        n_pa    = r_pa;
        n_me    = r_me;
        n_cap   = r_cap;
        if (i_accept) begin
            case (r_phase)
                PH_LEN_FIRST: begin
                    if (w_digit) begin
                        n_dl    = {12'd0, i_rx_byte[3:0]};
                        n_phase = PH_LEN_DIGITS;
                    end else begin
                        n_phase = PH_HUNT;
                        n_pm    = {2'd0, w_plus};
                        n_pos   = 16'd0;
                        n_pa    = 1'b0;
                    end
                end
                PH_LEN_DIGITS, PH_SKIP: begin
                    if ((r_phase == PH_LEN_DIGITS) && w_digit) begin
                        n_dl = w_len_next;
                    end else if (w_colon) begin
                        n_pos = 16'd0;
                        n_pa  = 1'b0;
                        if (w_len_over || w_len_zero) begin
                            n_phase = PH_HUNT;
                            n_pm    = 3'd0;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if ((r_phase == PH_LEN_DIGITS) ? SKIP_FIRST_OVF : w_skip_ovf) begin
                        n_phase = PH_HUNT;
                        n_pm    = {2'd0, w_plus};
                        n_pos   = 16'd0;
                        n_pa    = 1'b0;
                    end else begin
                        n_phase = PH_SKIP;
                        n_pos   = (r_phase == PH_LEN_DIGITS) ? 16'd1 : w_pos_inc[15:0];
                    end
                end
                PH_PAYLOAD: begin
                    if (r_pos == 16'd0) begin
                        n_pa = w_pub_start;
                        n_tl = 16'd0;
                        n_me = 16'd0;
                    end else if (r_pa) begin
                        if (r_pos == 16'd2) begin
                            n_tl = {i_rx_byte, 8'd0};
                        end else if (r_pos == 16'd3) begin
                            n_tl  = w_tl_new;
                            n_cap = w_cap;
                            if (w_topic_bad) begin
                                n_pa = 1'b0;
                            end
                        end else if (w_pos_ge4 && !w_in_topic && w_msg_more) begin
                            n_me = w_me_inc;
                        end
                    end
                    if (w_pay_done) begin
                        n_phase = PH_HUNT;
                        n_pm    = 3'd0;
                        n_pos   = 16'd0;
                        n_pa    = 1'b0;
                    end else begin
                        n_pos = w_pos_inc[15:0];
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (w_prefix_hit) begin
                        if (w_idx == 3'd4) begin
                            n_pm    = 3'd0;
                            n_dl    = 16'd0;
                            n_phase = PH_LEN_FIRST;
                        end else begin
                            n_pm = w_idx + 3'd1;
                        end
                    end else begin
                        n_pm = {2'd0, w_plus};
                    end
                end
            endcase
        end
    end

    // Result beat logic.
    always_comb begin
        logic emit;
        emit                 = 1'b0;
        o_res.data_byte      = 8'd0;
        o_res.event_res      = EV_OVERFLOW;
        o_res.end_of_message = 1'b0;
        case (r_phase)
            PH_LEN_DIGITS: begin
                if (!w_digit) begin
                    emit = w_colon ? w_len_over : SKIP_FIRST_OVF;
                end
            end
            PH_SKIP: begin
                emit = w_colon ? w_len_over : w_skip_ovf;
            end
            PH_PAYLOAD: begin
                if ((r_pos != 16'd0) && r_pa) begin
                    if (r_pos == 16'd3) begin
                        emit            = w_topic_bad;
                        o_res.event_res = EV_MALFORMED;
                    end else if (w_pos_ge4) begin
                        o_res.data_byte = i_rx_byte;
                        if (w_in_topic) begin
                            emit            = 1'b1;
                            o_res.event_res = EV_TOPIC;
                        end else begin
                            emit                 = w_msg_more;
                            o_res.event_res      = EV_MESSAGE;
                            o_res.end_of_message = (w_me_inc == r_cap);
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        o_push = emit && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_pm             <= 3'd0;
            r_dl             <= 16'd0;
            r_pos            <= 16'd0;
            r_tl             <= 16'd0;
            r_pa             <= 1'b0;
            r_me             <= 16'd0;
            r_cap            <= 16'd0;
            r_deliver_enable <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pm    <= n_pm;
            r_dl    <= n_dl;
            r_pos   <= n_pos;
            r_tl    <= n_tl;
            r_pa    <= n_pa;
            r_me    <= n_me;
            r_cap   <= n_cap;
            if (i_cfg_wr_en) begin
                r_deliver_enable <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ----- rtl/core/ipd_queue.sv -----
// Short result queue between the parser and the output stage.
// Depends on ipd_pkg for the result beat type.
module ipd_queue #(
    parameter int DEPTH = ipd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ipd_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_valid,
    output ipd_pkg::t_result o_data
);
    import ipd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/ipd_back.sv -----
// Back part: output register that presents result beats to the consumer.
// Depends on ipd_pkg; drains ipd_queue.
module ipd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ipd_pkg::t_result i_q_data,
    output logic             o_pop,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output ipd_pkg::t_result o_res
);
    import ipd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_pop       = i_q_valid && (!r_valid || i_res_ready);
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_res_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- rtl/core/ipd_mqtt_publish_deframer_top.sv -----
// Top level of the +IPD publish deframer: parser, result queue, output stage.
// Depends on ipd_pkg, ipd_front, ipd_queue and ipd_back.
//
//  Channel   Direction  Handshake                    Payload
//  rx        in         i_rx_valid / o_rx_ready      i_rx_byte[7:0]
//  result    out        o_res_valid / i_res_ready    o_data_byte, o_event_res, o_end_of_message
//  config    in         i_cfg_wr_en (no wait)        i_cfg_wr_data (deliver enable)
//
// Each received byte is parsed as it is taken, so one rx beat is taken every cycle
// while the result queue has room; the parser state update on each accepted byte sets that rate.
// A result beat is written into the queue when its rx beat is taken and is then moved
// into the output register, from which the consumer can take it.
// Reset is synchronous and active low, and there is no clearing pass.
// A stalled consumer first fills the output register, then the queue of QUEUE_DEPTH beats;
// only then does o_rx_ready drop, and bytes that give no result are not held back sooner.
module ipd_mqtt_publish_deframer_top #(
    parameter int QUEUE_DEPTH = ipd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_event_res,
    output logic       o_end_of_message
);
    import ipd_pkg::*;

    logic    w_accept;
    logic    w_push;
    t_result w_push_data;
    logic    w_q_valid;
    t_result w_q_data;
    logic    w_pop;
    t_result w_res;

    // Any byte can produce a result beat, so the parser only takes a byte
    // when the queue can hold one.
    assign w_accept = i_rx_valid && o_rx_ready;

    ipd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .o_push        (w_push),
        .o_res         (w_push_data)
    );

    ipd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_ready (o_rx_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    ipd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (w_res)
    );

    assign o_data_byte      = w_res.data_byte;
    assign o_event_res      = w_res.event_res;
    assign o_end_of_message = w_res.end_of_message;

    // The end-of-message flag only ever rides on a message byte.
    a_eom_on_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_end_of_message) |-> (o_event_res == EV_MESSAGE))
        else $error("end of message flagged on a non-message beat");

    // Error events carry a zero data byte.
    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && ((o_event_res == EV_MALFORMED) || (o_event_res == EV_OVERFLOW)))
        |-> (o_data_byte == 8'd0))
        else $error("error event with nonzero data byte");

    // A pushed result is never lost: next cycle it sits in the queue or the output stage.
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (w_q_valid || o_res_valid))
        else $error("result beat lost after push");

    // A push is only made while the queue has room.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> o_rx_ready)
        else $error("push into a full queue");

endmodule

// ----- tb/tb_ipd_mqtt_publish_deframer_top.sv -----
// Self-checking testbench for the +IPD publish deframer top level.
// Depends on ipd_pkg and ipd_mqtt_publish_deframer_top; it needs no other file.
`timescale 1ns / 100ps

module tb_ipd_mqtt_publish_deframer_top;
    import ipd_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int BYTES_PER_PHASE = 275;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 32;

    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] IPD_PREFIX [0:4] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
    localparam t_result NO_RESULT = '{8'h00, EV_TOPIC, 1'b0};

    // Delivery setting used for each random phase; both values are visited twice or more.
    localparam bit PHASE_DELIVER [0:NUM_PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_rx_valid;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte;
    logic       o_res_valid;
    logic       i_res_ready;
    logic [7:0] o_data_byte;
    logic [1:0] o_event_res;
    logic       o_end_of_message;

    ipd_mqtt_publish_deframer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_data_byte     (o_data_byte),
        .o_event_res     (o_event_res),
        .o_end_of_message(o_end_of_message)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result beats the deframer still owes us, oldest first.
    t_result expected_events [$];
    // Bytes of the frame currently being assembled for transmission.
    logic [7:0] frame_q [$];

    int err_count   = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int skip_runs   = 0;

    // ------------------------------------------------------------------
    // Deframer state as the testbench tracks it. It is updated once for
    // every rx beat that the block accepts, in acceptance order.
    // ------------------------------------------------------------------
    t_phase      dfr_phase      = PH_HUNT;
    logic [2:0]  dfr_prefix_cnt = '0;
    logic [15:0] dfr_len        = '0;
    logic [15:0] dfr_pos        = '0;
    logic [15:0] dfr_topic_len  = '0;
    logic        dfr_publish    = 1'b0;
    logic [15:0] dfr_msg_cnt    = '0;
    logic        dfr_deliver_en = 1'b0;

    // Leaving a frame for any reason restarts the prefix search; a '+' that
    // caused the exit already counts as the first prefix character.
    function automatic void rehunt(input logic [7:0] b);
        dfr_phase      = PH_HUNT;
        dfr_prefix_cnt = (b == CHR_PLUS) ? 3'd1 : 3'd0;
        dfr_pos        = '0;
        dfr_publish    = 1'b0;
    endfunction

    // The ':' that ends the header. Returns 1 when the declared length is
    // too large, which the block reports as an overflow.
    function automatic bit close_header();
        if (dfr_len > FRAME_LIMIT) begin
            rehunt(CHR_COLON);
            return 1'b1;
        end
        if (dfr_len == 16'd0) begin
            rehunt(CHR_COLON);
            return 1'b0;
        end
        dfr_phase   = PH_PAYLOAD;
        dfr_pos     = '0;
        dfr_publish = 1'b0;
        return 1'b0;
    endfunction

    // Advances the tracked state by one received byte. Returns 1 and fills r
    // when the byte gives a result beat.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        int unsigned pos;
        int unsigned cap;
        int unsigned v;
        bit          digit;
        bit          hit;

        digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
        hit   = 1'b0;
        r     = NO_RESULT;
        case (dfr_phase)
            PH_LEN_FIRST: begin
                if (digit) begin
                    dfr_len   = 16'(b - CHR_ZERO);
                    dfr_phase = PH_LEN_DIGITS;
                end else begin
                    rehunt(b);
                end
            end
            PH_LEN_DIGITS: begin
                if (digit) begin
                    // The decimal length saturates instead of wrapping.
                    v       = 32'(dfr_len) * 10 + 32'(b - CHR_ZERO);
                    dfr_len = (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
                end else if (b == CHR_COLON) begin
                    hit = close_header();
                    if (hit) r.event_res = EV_OVERFLOW;
                end else begin
                    // Text after the digits is skipped up to the colon.
                    dfr_phase = PH_SKIP;
                    dfr_pos   = 16'd1;
                end
            end
            PH_SKIP: begin
                if (b == CHR_COLON) begin
                    hit = close_header();
                    if (hit) r.event_res = EV_OVERFLOW;
                end else begin
                    dfr_pos = dfr_pos + 16'd1;
                    if (dfr_pos >= FRAME_LIMIT) begin
                        rehunt(b);
                        hit         = 1'b1;
                        r.event_res = EV_OVERFLOW;
                    end
                end
            end
            PH_PAYLOAD: begin
                pos = 32'(dfr_pos);
                if (pos == 0) begin
                    // Delivery enable only matters on the header byte.
                    dfr_publish   = (dfr_len > 16'd4) && ((b & HDR_MASK) == HDR_PUBLISH) &&
                                    dfr_deliver_en;
                    dfr_topic_len = '0;
                    dfr_msg_cnt   = '0;
                end else if (dfr_publish) begin
                    if (pos == 2) begin
                        dfr_topic_len = {b, 8'h00};
                    end else if (pos == 3) begin
                        dfr_topic_len[7:0] = b;
                        if (!((32'(dfr_topic_len) + 4 < 32'(dfr_len)) &&
                              (dfr_topic_len < TOPIC_LIMIT))) begin
                            dfr_publish = 1'b0;
                            hit         = 1'b1;
                            r.event_res = EV_MALFORMED;
                        end
                    end else if (pos >= 4) begin
                        if (pos < 32'd4 + 32'(dfr_topic_len)) begin
                            hit         = 1'b1;
                            r.data_byte = b;
                            r.event_res = EV_TOPIC;
                        end else begin
                            // The message is cut one byte short of the message limit.
                            cap = 32'(dfr_len) - 32'd4 - 32'(dfr_topic_len);
                            if (cap > 32'(MESSAGE_LIMIT) - 1) cap = 32'(MESSAGE_LIMIT) - 1;
                            if (32'(dfr_msg_cnt) < cap) begin
                                dfr_msg_cnt      = dfr_msg_cnt + 16'd1;
                                hit              = 1'b1;
                                r.data_byte      = b;
                                r.event_res      = EV_MESSAGE;
                                r.end_of_message = (32'(dfr_msg_cnt) == cap);
                            end
                        end
                    end
                end
                pos = pos + 1;
                if (pos >= 32'(dfr_len)) begin
                    dfr_phase      = PH_HUNT;
                    dfr_prefix_cnt = '0;
                    dfr_pos        = '0;
                    dfr_publish    = 1'b0;
                end else begin
                    dfr_pos = pos[15:0];
                end
            end
            default: begin
                dfr_phase = PH_HUNT;
                if (dfr_prefix_cnt > 3'd4) dfr_prefix_cnt = '0;
                if (b == IPD_PREFIX[dfr_prefix_cnt]) begin
                    dfr_prefix_cnt = dfr_prefix_cnt + 3'd1;
                    if (dfr_prefix_cnt == 3'd5) begin
                        dfr_prefix_cnt = '0;
                        dfr_len        = '0;
                        dfr_phase      = PH_LEN_FIRST;
                    end
                end else begin
                    dfr_prefix_cnt = (b == CHR_PLUS) ? 3'd1 : 3'd0;
                end
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Only the overflow event and the final marked message
    // byte carry a typed expectation; the rest go through the tracker.
    //   "+IPD,+"  : no digits, and the '+' restarts the prefix match
    //   "IPD,999:": declared length over the frame limit -> overflow
    //   "+IPD,7:" : publish with a one-byte topic and a two-byte message,
    //               header low nibble all ones, data bytes at 00 and FF
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] rx;
        bit         typed;
        t_result    res;
    } t_dir_row;

    t_dir_row directed_rows [0:27] = '{
        '{8'h2B, 1'b0, NO_RESULT}, '{8'h49, 1'b0, NO_RESULT}, '{8'h50, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, NO_RESULT}, '{8'h2C, 1'b0, NO_RESULT}, '{8'h2B, 1'b0, NO_RESULT},
        '{8'h49, 1'b0, NO_RESULT}, '{8'h50, 1'b0, NO_RESULT}, '{8'h44, 1'b0, NO_RESULT},
        '{8'h2C, 1'b0, NO_RESULT}, '{8'h39, 1'b0, NO_RESULT}, '{8'h39, 1'b0, NO_RESULT},
        '{8'h39, 1'b0, NO_RESULT},
        '{8'h3A, 1'b1, '{8'h00, EV_OVERFLOW, 1'b0}},
        '{8'h2B, 1'b0, NO_RESULT}, '{8'h49, 1'b0, NO_RESULT}, '{8'h50, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, NO_RESULT}, '{8'h2C, 1'b0, NO_RESULT}, '{8'h37, 1'b0, NO_RESULT},
        '{8'h3A, 1'b0, NO_RESULT},
        '{8'h3F, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT}, '{8'h54, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{8'hFF, EV_MESSAGE, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Frame builders for the random part.
    // ------------------------------------------------------------------
    function automatic void push_text(input string s);
        foreach (s[k]) frame_q.push_back(s[k]);
    endfunction

    function automatic logic [7:0] rand_not_colon();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHR_COLON);
        return b;
    endfunction

    // "+IPD,<len>[,text]:" with occasional leading zeros and header text.
    function automatic void push_frame_head(input int unsigned len);
        push_text("+IPD,");
        if ($urandom_range(0, 7) == 0) push_text("00");
        push_text($sformatf("%0d", len));
        if ($urandom_range(0, 3) == 0) begin
            frame_q.push_back(CHR_COMMA);
            repeat ($urandom_range(0, 6)) frame_q.push_back(rand_not_colon());
        end
        frame_q.push_back(CHR_COLON);
    endfunction

    // Appends one frame (or some line noise) to frame_q. Most frames are
    // well-formed publishes with random content so that the topic and
    // message paths get exercised; the rest are the various broken cases.
    function automatic void build_frame();
        int unsigned roll;
        int unsigned tl;
        int unsigned ml;
        int unsigned dl;
        logic [7:0]  hdr;
        logic [7:0]  b;

        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            tl = ($urandom_range(0, 9) == 0) ? 32'(TOPIC_LIMIT) - 1 : $urandom_range(0, 8);
            ml = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 300) :
                 ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            dl = 4 + tl + ml;
            push_frame_head(dl);
            frame_q.push_back(HDR_PUBLISH | 8'($urandom_range(0, 15)));
            frame_q.push_back(8'($urandom));
            frame_q.push_back(tl[15:8]);
            frame_q.push_back(tl[7:0]);
            repeat (tl + ml) frame_q.push_back(8'($urandom));
        end else if (roll < 65) begin
            // Topic length too long for the frame or over the topic limit.
            dl = $urandom_range(5, 40);
            tl = $urandom_range(0, 1) ? $urandom_range(32'(TOPIC_LIMIT), 65535) :
                 $urandom_range(dl - 4, dl + 8);
            push_frame_head(dl);
            frame_q.push_back(HDR_PUBLISH | 8'($urandom_range(0, 15)));
            frame_q.push_back(8'($urandom));
            frame_q.push_back(tl[15:8]);
            frame_q.push_back(tl[7:0]);
            repeat (dl - 4) frame_q.push_back(8'($urandom));
        end else if (roll < 75) begin
            // Not a publish: short payload, or a header of another type.
            if ($urandom_range(0, 1)) begin
                dl  = $urandom_range(1, 4);
                hdr = HDR_PUBLISH | 8'($urandom_range(0, 15));
            end else begin
                dl  = ($urandom_range(0, 9) == 0) ? 32'(FRAME_LIMIT) : $urandom_range(5, 30);
                hdr = 8'($urandom);
                if ((hdr & HDR_MASK) == HDR_PUBLISH) hdr = hdr ^ 8'h80;
            end
            push_frame_head(dl);
            frame_q.push_back(hdr);
            repeat (dl - 1) frame_q.push_back(8'($urandom));
        end else if (roll < 80) begin
            // Declared length over the frame limit, sometimes beyond 16 bits.
            push_frame_head($urandom_range(32'(FRAME_LIMIT) + 1, 999999));
            repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
        end else if (roll < 84) begin
            push_frame_head(0);
        end else if (roll < 90) begin
            push_text("+IPD,");
            do b = 8'($urandom); while ((b >= CHR_ZERO) && (b <= CHR_NINE));
            frame_q.push_back(b);
        end else if ((roll >= 98) && (skip_runs < 3)) begin
            // Header text that never reaches a colon runs into the frame limit.
            skip_runs++;
            push_text("+IPD,5,");
            repeat (32'(FRAME_LIMIT) + 8) frame_q.push_back(rand_not_colon());
        end else begin
            if ($urandom_range(0, 1)) push_text("+IP");
            repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender. It is always called at a falling edge and returns at the
    // falling edge after its beat was taken. Beats go out in bursts of
    // random length with random gaps between them; valid is only lowered
    // when a real gap follows, so it never drops and rises in one step.
    // ------------------------------------------------------------------
    task automatic send_rx(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        @(negedge i_clk);
    endtask

    // Waits until the block has nothing left to deliver, lets it settle,
    // then writes the delivery enable. The sender is held off meanwhile.
    task automatic set_deliver(input logic en);
        i_rx_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en    <= 1'b1;
        i_cfg_wr_data  <= en;
        dfr_deliver_en  = en;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Receiver back-pressure. Every stretch picks one of three patterns:
    // always ready, randomly ready with a probability of three in four, or a regular
    // on/off pattern whose stall part can be long enough to fill the
    // result queue and push back on the rx side.
    // ------------------------------------------------------------------
    initial begin : res_ready_gen
        int mode;
        int span;
        int on_len;
        int off_len;
        i_res_ready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 2);
            span    = $urandom_range(20, 120);
            on_len  = $urandom_range(1, 8);
            off_len = $urandom_range(1, 16);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_res_ready <= 1'b1;
                    1:       i_res_ready <= ($urandom_range(0, 3) != 0);
                    default: i_res_ready <= ((k % (on_len + off_len)) < on_len);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result beat is compared field by field with the
    // oldest expectation. Reports are capped to keep the log readable.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_events.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: unexpected result beat: expected none, actual data %02h event %0d eom %0b",
                             $time, o_data_byte, o_event_res, o_end_of_message);
                err_count++;
            end else begin
                want = expected_events.pop_front();
                if (o_data_byte !== want.data_byte) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data_byte, o_data_byte);
                    err_count++;
                end
                if (o_event_res !== want.event_res) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: event_res mismatch: expected %0d, actual %0d",
                                 $time, want.event_res, o_event_res);
                    err_count++;
                end
                if (o_end_of_message !== want.end_of_message) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: end_of_message mismatch: expected %0b, actual %0b",
                                 $time, want.end_of_message, o_end_of_message);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: a run of cycles with no beat on either channel is a hang.
    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[ipd_mqtt_publish_deframer_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed rows with delivery enabled, then the
    // random phases, each with its own delivery setting. Every setting
    // change waits for the block to drain, which also gives the sender a
    // full pause until all expected results have arrived.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_result r;
        int      sent;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_rx_valid    = 1'b0;
        i_rx_byte     = 8'h00;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_deliver(1'b1);
        foreach (directed_rows[k]) begin
            send_rx(directed_rows[k].rx);
            if (deframe_byte(directed_rows[k].rx, r) && !directed_rows[k].typed)
                expected_events.push_back(r);
            if (directed_rows[k].typed)
                expected_events.push_back(directed_rows[k].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_deliver(PHASE_DELIVER[p]);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_frame();
                while (frame_q.size() != 0) begin
                    send_rx(frame_q[0]);
                    if (deframe_byte(frame_q.pop_front(), r)) expected_events.push_back(r);
                    sent++;
                end
            end
        end

        i_rx_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("[ipd_mqtt_publish_deframer_top] OK");
        end else begin
            $display("[ipd_mqtt_publish_deframer_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ipd_pkg.sv
rtl/core/ipd_front.sv
rtl/core/ipd_queue.sv
rtl/core/ipd_back.sv
rtl/core/ipd_mqtt_publish_deframer_top.sv
tb/tb_ipd_mqtt_publish_deframer_top.sv
